// ----- rtl/smv_pkg.sv -----
package smv_pkg;

  // Vector store geometry
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);

  // Field widths
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;

  // Input item kinds (tuser bit 0)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  // Configuration register indexes (paddr bit 2)
  localparam logic REG_ADD_MODE = 1'b0;
  localparam logic REG_SCALE    = 1'b1;

  // Column or element index to store address
  function automatic logic [VEC_AW-1:0] vec_addr(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[VEC_AW-1:0];
  endfunction

  // Index lies inside the store
  function automatic logic vec_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(VEC_DEPTH);
  endfunction

endpackage

// ----- rtl/sparse_mcsr_matvec.sv -----
// Sparse matrix (modified CSR, diagonal first) times dense vector.
// Input stream in_*: tdata = index[9:0], value[41:10], prior_sum[73:42];
// tuser = op[0], row_start[1]; tlast = row_end. op 0 loads one vector
// element, op 1 is one matrix entry. Rows start with their diagonal entry.
// Output stream out_*: tdata = row_number[9:0], row_sum[41:10], one beat
// per entry that ends a row.
// Config (APB): 0x0 add_mode, 0x4 scale; write only while idle.
// A load beat with an in-range index is written to the store at accept.
// A matrix entry runs through the store read, the shared multiply and
// the accumulate. An entry that ends a row then reaches the output
// register through the EMIT state, after a second pass through the same
// multiplier for the scale in add mode (SCL state). The next beat is
// taken only when the sequencer is back in IDLE. The single 32x32
// multiplier and the single-port vector store set this sequence.
// Reset (rst_n low, synchronous) clears accumulator, current row, the
// output valid flag and config (add_mode 0, scale 1); store contents
// stay undefined until loaded.
// A stalled receiver holds the result in the output register; the block
// still takes the next beat, and only waits when a second result is ready.
module sparse_mcsr_matvec
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: index[9:0], value[41:10], prior_sum[73:42], zeros[79:74]
  input  logic [79:0] in_tdata,
  // in_tuser: op[0], row_start[1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: row_number[9:0], row_sum[41:10], zeros[47:42]
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_SCL  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              add_mode_r;
  logic [DATA_W-1:0] scale_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]  cur_row_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] val_r, prior_r;
  logic              rs_r, re_r, rng_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [DATA_W-1:0] out_sum_r;

  logic [IDX_W-1:0]  in_index;
  logic [DATA_W-1:0] in_value, in_prior;
  logic              in_op, in_rs, in_accept;
  logic              cfg_wr;
  logic              ram_en, ram_we;
  logic [DATA_W-1:0] ram_rdata;
  logic              mul_en;
  logic [DATA_W-1:0] mul_a, mul_b, mul_p;
  logic              emit_load;
  logic [DATA_W-1:0] sum_nxt;

  // Unpack the input beat
  assign in_index  = in_tdata[9:0];
  assign in_value  = in_tdata[41:10];
  assign in_prior  = in_tdata[73:42];
  assign in_op     = in_tuser[0];
  assign in_rs     = in_tuser[1];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Config registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_mode_r <= 1'b0;
      scale_r    <= 32'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ADD_MODE: add_mode_r <= cfg_pwdata[0];
        REG_SCALE:    scale_r    <= cfg_pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ADD_MODE: cfg_prdata = {31'd0, add_mode_r};
      REG_SCALE:    cfg_prdata = scale_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Vector store: loads write at accept, entries read at accept
  assign ram_en = in_accept && (in_op == OP_ENTRY || vec_in_range(in_index));
  assign ram_we = (in_op == OP_LOAD);

  smv_vec_ram u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (vec_addr(in_index)),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  // Shared multiplier: entry product, then scale times row sum
  always_comb begin
    mul_en = 1'b0;
    mul_a  = val_r;
    mul_b  = rng_r ? ram_rdata : '0;
    if (state_r == ST_RD) begin
      mul_en = 1'b1;
    end else if (state_r == ST_SCL) begin
      mul_en = 1'b1;
      mul_a  = scale_r;
      mul_b  = acc_r;
    end
  end

  smv_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Latch the entry fields
  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_ENTRY) begin
      idx_r   <= in_index;
      val_r   <= in_value;
      prior_r <= in_prior;
      rs_r    <= in_rs;
      re_r    <= in_tlast;
      rng_r   <= vec_in_range(in_index);
    end
  end

  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign sum_nxt   = add_mode_r ? prior_r + mul_p : acc_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: if (in_accept && in_op == OP_ENTRY) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = rs_r ? mul_p : acc_r + mul_p;
        if (!re_r) begin
          state_nxt = ST_IDLE;
        end else if (add_mode_r) begin
          state_nxt = ST_SCL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          acc_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= '0;
      cur_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      if (state_r == ST_ACC && rs_r) begin
        cur_row_r <= idx_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_row_r <= cur_row_r;
      out_sum_r <= sum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_sum_r, out_row_r};

`ifndef SYNTHESIS
  // A matrix entry starts the store read pass
  a_entry_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_op == OP_ENTRY |=> state_r == ST_RD)
    else $error("matrix entry did not start the read pass");

  // A row start takes its row number
  a_row_taken: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC && rs_r |=> cur_row_r == $past(idx_r))
    else $error("row start did not set the current row");

  // Emitting a row fills the output and clears the accumulator
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> out_valid_r && acc_r == '0 && state_r == ST_IDLE)
    else $error("row emit did not complete");
`endif

endmodule

// ----- rtl/smv_vec_ram.sv -----
module smv_vec_ram
  import smv_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [VEC_AW-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [VEC_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smv_mul.sv -----
module smv_mul
  import smv_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] p
);

  logic [DATA_W-1:0] p_r;
  logic [DATA_W-1:0] p_nxt;

  // Low word of the product, wraps like two's complement
  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- tb/sparse_mcsr_matvec_test.sv -----
module sparse_mcsr_matvec_test;
  import smv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 12;   // settling wait after all rows return
  localparam int HOLD_LEN    = 400;

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic              row_start;
    logic              row_end;
    logic [DATA_W-1:0] prior_sum;
  } smv_beat_t;

  typedef struct {
    logic [IDX_W-1:0]  row_number;
    logic [DATA_W-1:0] row_sum;
  } row_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sparse_mcsr_matvec i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Stimulus bookkeeping
  smv_beat_t   beat_feed[$];
  row_result_t due_rows[$];
  bit          gen_loaded[VEC_DEPTH];
  int          loaded_list[$];
  int          gen_items = 0;
  bit          steady = 1'b0;      // no random gaps or stalls on either side
  int          hold_asks = 0;

  // Predictor state
  logic [DATA_W-1:0] vec_mem[VEC_DEPTH];
  logic [DATA_W-1:0] acc_q = '0;
  logic [IDX_W-1:0]  row_q = '0;
  logic              add_mode_q = 1'b0;
  logic [DATA_W-1:0] scale_q = 32'd1;

  // Run statistics
  int fails = 0;
  int loads_seen = 0;
  int entries_seen = 0;
  int rows_checked = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mirror of the block: store, accumulator, current row
  task automatic predict_row_sum(input smv_beat_t b);
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] scaled;
    row_result_t res;
    if (b.op == OP_LOAD) begin
      loads_seen++;
      if (int'(b.index) < VEC_DEPTH) vec_mem[b.index] = b.value;
    end else begin
      entries_seen++;
      prod = (int'(b.index) < VEC_DEPTH) ? b.value * vec_mem[b.index] : '0;
      if (b.row_start) begin
        row_q = b.index;
        acc_q = prod;
      end else begin
        acc_q = acc_q + prod;
      end
      if (b.row_end) begin
        scaled = scale_q * acc_q;
        res.row_number = row_q;
        res.row_sum = add_mode_q ? b.prior_sum + scaled : acc_q;
        due_rows.push_back(res);
        acc_q = '0;
      end
    end
  endtask

  task automatic push_load(input int idx, input logic [31:0] val);
    smv_beat_t b;
    b = '{OP_LOAD, idx[IDX_W-1:0], val, 1'b0, 1'b0, rand_word()};
    beat_feed.push_back(b);
    if (!gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    gen_items++;
  endtask

  task automatic push_entry(input int idx, input logic [31:0] val, input bit rs,
                            input bit re, input logic [31:0] prior);
    smv_beat_t b;
    b = '{OP_ENTRY, idx[IDX_W-1:0], val, rs, re, prior};
    beat_feed.push_back(b);
    gen_items++;
  endtask

  // Only columns already loaded are ever read
  function automatic int pick_col();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Mostly well-formed rows, some loads, stray entries and abandoned rows
  task automatic gen_random(input int n);
    int target;
    int r;
    int k;
    target = gen_items + n;
    while (gen_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        push_load($urandom_range(0, VEC_DEPTH - 1), rand_word());
      end else if (r < 85) begin
        k = $urandom_range(0, 5);
        push_entry(pick_col(), rand_word(), 1'b1, k == 0, rand_word());
        for (int j = 1; j <= k; j++) begin
          if ($urandom_range(0, 9) == 0)
            push_load($urandom_range(0, VEC_DEPTH - 1), rand_word());
          push_entry(pick_col(), rand_word(), 1'b0, j == k, rand_word());
        end
      end else if (r < 93) begin
        push_entry(pick_col(), rand_word(), 1'b0, 1'($urandom_range(0, 1)), rand_word());
      end else begin
        k = $urandom_range(0, 3);
        push_entry(pick_col(), rand_word(), 1'b1, 1'b0, rand_word());
        for (int j = 0; j < k; j++)
          push_entry(pick_col(), rand_word(), 1'b0, 1'b0, rand_word());
      end
    end
  endtask

  // Wait for the block to go quiet: all beats sent, all rows returned.
  // Sampled mid-cycle so the driver's updates of this edge are settled.
  task automatic wait_idle();
    @(negedge clk);
    while (beat_feed.size() != 0 || in_tvalid || due_rows.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_ADD_MODE) add_mode_q = data[0];
    else scale_q = data;
    cfg_writes++;
  endtask

  task automatic flag_mismatch(input string what, input row_result_t e,
                               input logic [IDX_W-1:0] g_row,
                               input logic [DATA_W-1:0] g_sum);
    fails++;
    if (fails <= 10)
      $display("%s: expected row %0d sum %0d, got row %0d sum %0d", what,
               e.row_number, $signed(e.row_sum), g_row, $signed(g_sum));
  endtask

  // Input driver: one beat per handshake, random gaps between beats
  smv_beat_t beat_now;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) predict_row_sum(beat_now);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (beat_feed.size() > 0) begin
          beat_now = beat_feed.pop_front();
          in_tdata  <= {6'b0, beat_now.prior_sum, beat_now.value, beat_now.index};
          in_tuser  <= {beat_now.row_start, beat_now.op};
          in_tlast  <= beat_now.row_end;
          in_tvalid <= 1'b1;
          gap_left = steady ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  int          hold_done = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  row_result_t row_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rows_checked++;
        if (due_rows.size() == 0) begin
          row_exp = '{'0, '0};
          flag_mismatch("unexpected row", row_exp, out_tdata[9:0], out_tdata[41:10]);
        end else begin
          row_exp = due_rows.pop_front();
          if (out_tdata[9:0] !== row_exp.row_number || out_tdata[41:10] !== row_exp.row_sum)
            flag_mismatch("row mismatch", row_exp, out_tdata[9:0], out_tdata[41:10]);
        end
      end
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = steady ? 0 : pick_gap();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d rows still due", cycle_count, due_rows.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (overwrite mode, scale 1)
    push_load(0, 32'h7FFF_FFFF);
    push_load(VEC_DEPTH - 1, 32'h8000_0000);
    push_load(512, 32'hFFFF_FFFF);
    push_load(1, 32'h0);
    push_load(5, 32'd3);
    // diagonal-only row
    push_entry(0, 32'd2, 1'b1, 1'b1, rand_word());
    // full row over the extreme columns
    push_entry(VEC_DEPTH - 1, 32'hFFFF_FFFF, 1'b1, 1'b0, rand_word());
    push_entry(0, 32'h8000_0000, 1'b0, 1'b0, rand_word());
    push_entry(512, 32'd7, 1'b0, 1'b1, 32'h7FFF_FFFF);
    // entries with no row start reuse the kept row number
    push_entry(5, 32'd4, 1'b0, 1'b0, rand_word());
    push_entry(5, 32'd1, 1'b0, 1'b1, rand_word());
    // abandoned row, then a fresh one
    push_entry(5, 32'd9, 1'b1, 1'b0, rand_word());
    push_entry(1, 32'd5, 1'b1, 1'b1, rand_word());
    // load in the middle of a row
    push_entry(5, 32'd2, 1'b1, 1'b0, rand_word());
    push_load(5, 32'd11);
    push_entry(5, 32'd6, 1'b0, 1'b1, rand_word());
    for (int j = 0; j < 64; j++)
      push_load($urandom_range(0, VEC_DEPTH - 1), rand_word());
    gen_random(140);
    wait_idle();

    // Add mode, scale 1
    reg_write(REG_ADD_MODE, 32'd1);
    push_entry(0, 32'd3, 1'b1, 1'b1, 32'h7FFF_FFFF);
    push_entry(VEC_DEPTH - 1, 32'd1, 1'b1, 1'b0, rand_word());
    push_entry(512, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h8000_0000);
    gen_random(200);
    wait_idle();

    // Scale -1 with a long receiver hold while the sender keeps going
    reg_write(REG_SCALE, 32'hFFFF_FFFF);
    steady = 1'b1;
    hold_asks++;
    gen_random(150);
    wait_idle();
    steady = 1'b0;

    reg_write(REG_SCALE, 32'h8000_0000);
    gen_random(200);
    wait_idle();

    reg_write(REG_SCALE, 32'h7FFF_FFFF);
    gen_random(200);
    wait_idle();

    reg_write(REG_SCALE, 32'h0);
    gen_random(100);
    wait_idle();

    reg_write(REG_SCALE, $urandom);
    gen_random(200);
    wait_idle();

    // Back to overwrite mode with a stray scale
    reg_write(REG_ADD_MODE, 32'd0);
    reg_write(REG_SCALE, $urandom);
    gen_random(150);
    wait_idle();

    fails += due_rows.size();
    $display("Sent %0d vector loads and %0d matrix entries across %0d register writes;",
             loads_seen, entries_seen, cfg_writes);
    $display("compared %0d row results, %0d mismatches.", rows_checked, fails);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
